// ----- hdl/ole_pkg.sv -----
// Package for the ordered list engine: word types, command and status codes,
// sequencer states and size constants. Depends on nothing else.
`timescale 1ns / 1ps

package ole_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int DATA_W    = 32;
   localparam int POS_W     = 5;

   typedef enum logic [2:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_END   = 3'd1,
      CMD_INS_POS   = 3'd2,
      CMD_DEL_FRONT = 3'd3,
      CMD_DEL_END   = 3'd4,
      CMD_DEL_POS   = 3'd5,
      CMD_SEARCH    = 3'd6,
      CMD_READOUT   = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_EMPTY     = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_BAD_POS   = 3'd3,
      STAT_NOT_FOUND = 3'd4,
      STAT_BAD_CMD   = 3'd5
   } status_type;

   typedef struct packed {
      cmd_type                    command;
      logic signed [DATA_W-1:0]   value;
      logic        [POS_W-1:0]    position;
   } req_word_type;

   typedef struct packed {
      status_type                 status;
      logic signed [DATA_W-1:0]   value_out;
      logic        [POS_W-1:0]    found_position;
      logic                       last;
   } rsp_word_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_RD,
      S_INS_WR,
      S_INS_PUT,
      S_DEL_FETCH,
      S_DEL_TAKE,
      S_DEL_RD,
      S_DEL_WR,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_OUT_RD,
      S_OUT_EMIT,
      S_RESP
   } seq_state_type;

endpackage

// ----- hdl/ole_store.sv -----
// Entry memory of the ordered list engine: one write port and one read port
// with registered read data. Depends on ole_pkg for the data width.
`timescale 1ns / 1ps

module ole_store
   import ole_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/ole_seq.sv -----
// Sequencer of the ordered list engine: decodes a command, walks the entry
// memory one entry per step, compares entries for a search, and builds result words.
// Depends on ole_pkg and ole_store.
`timescale 1ns / 1ps

module ole_seq
   import ole_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   localparam int AW   = $clog2(DEPTH),
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_word_type  req_word,
   input  logic          slot_free,
   output logic          out_load,
   output rsp_word_type  out_word
);

   localparam int PW = (CW > POS_W) ? CW + 1 : POS_W + 1;

   seq_state_type        state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [DATA_W-1:0]    value_ff, value_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [CW-1:0]        ptr_ff, ptr_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        count_ff, count_in;
   rsp_word_type         res_ff, res_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [DATA_W-1:0]    wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [DATA_W-1:0]    rd_data;

   logic [PW-1:0]        pos_ext;
   logic [PW-1:0]        cnt_ext;
   logic                 ins_pos_bad;
   logic                 del_pos_bad;
   logic [CW-1:0]        pos_idx;
   logic [CW-1:0]        ptr_inc;
   logic [CW-1:0]        ptr_dec;
   logic                 match;

   ole_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign pos_ext     = PW'(pos_ff);
   assign cnt_ext     = PW'(count_ff);
   assign ins_pos_bad = (pos_ext == '0) || (pos_ext > cnt_ext + PW'(1));
   assign del_pos_bad = (pos_ext == '0) || (pos_ext > cnt_ext);
   assign pos_idx     = CW'(pos_ext - PW'(1));
   assign ptr_inc     = ptr_ff + CW'(1);
   assign ptr_dec     = ptr_ff - CW'(1);
   assign match       = (rd_data == value_ff);

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      value_ff <= value_in;
      pos_ff   <= pos_in;
      ptr_ff   <= ptr_in;
      idx_ff   <= idx_in;
      res_ff   <= res_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      value_in = value_ff;
      pos_in   = pos_ff;
      ptr_in   = ptr_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = AW'(ptr_ff);
      wr_data  = rd_data;
      rd_en    = 1'b0;
      rd_addr  = AW'(ptr_ff);
      out_load = 1'b0;
      out_word = res_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_word.command;
               value_in = req_word.value;
               pos_in   = req_word.position;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            res_in = '{status: STAT_OK, value_out: '0, found_position: '0, last: 1'b1};
            ptr_in = '0;
            case (cmd_ff)
               CMD_INS_FRONT, CMD_INS_END, CMD_INS_POS: begin
                  if (count_ff == CW'(DEPTH)) begin
                     res_in.status = STAT_FULL;
                     state_in      = S_RESP;
                  end else if (cmd_ff == CMD_INS_POS && ins_pos_bad) begin
                     res_in.status = STAT_BAD_POS;
                     state_in      = S_RESP;
                  end else begin
                     if (cmd_ff == CMD_INS_FRONT) begin
                        idx_in = '0;
                     end else if (cmd_ff == CMD_INS_END) begin
                        idx_in = count_ff;
                     end else begin
                        idx_in = pos_idx;
                     end
                     ptr_in   = count_ff;
                     state_in = (count_ff == idx_in) ? S_INS_PUT : S_INS_RD;
                  end
               end
               CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_POS: begin
                  if (count_ff == '0) begin
                     res_in.status = STAT_EMPTY;
                     state_in      = S_RESP;
                  end else if (cmd_ff == CMD_DEL_POS && del_pos_bad) begin
                     res_in.status = STAT_BAD_POS;
                     state_in      = S_RESP;
                  end else begin
                     if (cmd_ff == CMD_DEL_FRONT) begin
                        ptr_in = '0;
                     end else if (cmd_ff == CMD_DEL_END) begin
                        ptr_in = count_ff - CW'(1);
                     end else begin
                        ptr_in = pos_idx;
                     end
                     state_in = S_DEL_FETCH;
                  end
               end
               CMD_SEARCH, CMD_READOUT: begin
                  if (count_ff == '0) begin
                     res_in.status = STAT_EMPTY;
                     state_in      = S_RESP;
                  end else begin
                     state_in = (cmd_ff == CMD_SEARCH) ? S_SRCH_RD : S_OUT_RD;
                  end
               end
               default: begin
                  res_in.status = STAT_BAD_CMD;
                  state_in      = S_RESP;
               end
            endcase
         end

         S_INS_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(ptr_dec);
            state_in = S_INS_WR;
         end

         S_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(ptr_ff);
            wr_data  = rd_data;
            ptr_in   = ptr_dec;
            state_in = (ptr_dec == idx_ff) ? S_INS_PUT : S_INS_RD;
         end

         S_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(idx_ff);
            wr_data  = value_ff;
            count_in = count_ff + CW'(1);
            state_in = S_RESP;
         end

         S_DEL_FETCH: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(ptr_ff);
            state_in = S_DEL_TAKE;
         end

         S_DEL_TAKE: begin
            res_in.value_out = rd_data;
            if (ptr_inc == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_RESP;
            end else begin
               state_in = S_DEL_RD;
            end
         end

         S_DEL_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(ptr_inc);
            state_in = S_DEL_WR;
         end

         S_DEL_WR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(ptr_ff);
            wr_data = rd_data;
            ptr_in  = ptr_inc;
            if (ptr_inc + CW'(1) == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_RESP;
            end else begin
               state_in = S_DEL_RD;
            end
         end

         S_SRCH_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(ptr_ff);
            state_in = S_SRCH_CMP;
         end

         S_SRCH_CMP: begin
            if (match) begin
               res_in.found_position = POS_W'(ptr_inc);
               state_in              = S_RESP;
            end else if (ptr_inc == count_ff) begin
               res_in.status = STAT_NOT_FOUND;
               state_in      = S_RESP;
            end else begin
               ptr_in   = ptr_inc;
               state_in = S_SRCH_RD;
            end
         end

         S_OUT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(ptr_ff);
            state_in = S_OUT_EMIT;
         end

         S_OUT_EMIT: begin
            out_word = '{status: STAT_OK, value_out: rd_data, found_position: '0,
                         last: (ptr_inc == count_ff)};
            if (slot_free) begin
               out_load = 1'b1;
               if (ptr_inc == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  ptr_in   = ptr_inc;
                  state_in = S_OUT_RD;
               end
            end
         end

         S_RESP: begin
            out_word = res_ff;
            if (slot_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("Entry count exceeds the list depth.");

   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) <= count_ff))
      else $error("Memory write lands beyond the occupied span.");

   assert property (@(posedge clock) disable iff (reset)
      out_load && out_word.status == STAT_FULL |-> count_ff == CW'(DEPTH))
      else $error("Full status reported on a list that is not full.");

   assert property (@(posedge clock) disable iff (reset)
      out_load && out_word.status == STAT_EMPTY |-> count_ff == '0)
      else $error("Empty status reported on a list that holds entries.");

endmodule

// ----- hdl/ordered_list_engine_top.sv -----
// A command walks the entry memory step by step, at most DEPTH entries, with one registered read and
// one write or compare of the entry memory per step.
// Throughput: one command at a time; req_stall stays high until the command has finished.
// A readout reads each entry and then delivers it as one word, and holds while the result side stalls.
// Reset clears the entry count and the output valid flag; the entry memory and output word are not cleared.
`timescale 1ns / 1ps

module ordered_list_engine_top
   import ole_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_word_type  req_word,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_word_type  rsp_word
);

   logic          rsp_valid_ff;
   rsp_word_type  rsp_word_ff;
   logic          slot_free;
   logic          out_load;
   rsp_word_type  out_word;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   ole_seq #(.DEPTH(DEPTH)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .slot_free (slot_free),
      .out_load  (out_load),
      .out_word  (out_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (slot_free) begin
         rsp_valid_ff <= out_load;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free && out_load) begin
         rsp_word_ff <= out_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for ordered_list_engine_top: directed table, then biased random commands,
// checked against the table's expected words or a shadow list kept by the bench. Needs ole_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
   import ole_pkg::*;

   localparam int LIST_DEPTH     = DEPTH_DEF;
   localparam int RANDOM_ITEMS   = 154;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SQUEEZE_CYCLES = 400;

   typedef struct {
      cmd_type                  command;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
      bit                       typed;
      status_type               want_status;
      logic signed [DATA_W-1:0] want_value;
   } drill_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   logic signed [DATA_W-1:0] shadow_list [LIST_DEPTH];
   int                       shadow_len;
   int                       peak_len;
   rsp_word_type             rsp_expected [$];
   drill_row_type            drill_rows [$];

   bit sender_idles;
   bit receiver_idles;
   bit squeeze;
   int mismatches;
   int commands_sent;
   int words_checked;
   int status_tally [8];
   int quiet_cycles;

   ordered_list_engine_top #(.DEPTH(LIST_DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void push_result(input status_type st, input logic signed [DATA_W-1:0] v,
                                       input logic [POS_W-1:0] fp, input logic lst);
      rsp_word_type r;
      r.status         = st;
      r.value_out      = v;
      r.found_position = fp;
      r.last           = lst;
      rsp_expected.push_back(r);
   endfunction

   // Updates the shadow list for one command and, if record is set, queues its result words.
   function automatic void list_apply(input req_word_type w, input bit record);
      int                       slot;
      int                       pos;
      int                       i;
      int                       hit;
      logic signed [DATA_W-1:0] taken;
      pos = int'(w.position);
      case (w.command)
         CMD_INS_FRONT, CMD_INS_END, CMD_INS_POS: begin
            if (shadow_len >= LIST_DEPTH) begin
               if (record) push_result(STAT_FULL, '0, '0, 1'b1);
            end else if (w.command == CMD_INS_POS && (pos < 1 || pos > shadow_len + 1)) begin
               if (record) push_result(STAT_BAD_POS, '0, '0, 1'b1);
            end else begin
               if (w.command == CMD_INS_FRONT) slot = 0;
               else if (w.command == CMD_INS_END) slot = shadow_len;
               else slot = pos - 1;
               for (i = shadow_len; i > slot; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[slot] = w.value;
               shadow_len++;
               if (shadow_len > peak_len) peak_len = shadow_len;
               if (record) push_result(STAT_OK, '0, '0, 1'b1);
            end
         end
         CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_POS: begin
            if (shadow_len == 0) begin
               if (record) push_result(STAT_EMPTY, '0, '0, 1'b1);
            end else if (w.command == CMD_DEL_POS && (pos < 1 || pos > shadow_len)) begin
               if (record) push_result(STAT_BAD_POS, '0, '0, 1'b1);
            end else begin
               if (w.command == CMD_DEL_FRONT) slot = 0;
               else if (w.command == CMD_DEL_END) slot = shadow_len - 1;
               else slot = pos - 1;
               taken = shadow_list[slot];
               for (i = slot; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
               shadow_len--;
               if (record) push_result(STAT_OK, taken, '0, 1'b1);
            end
         end
         CMD_SEARCH: begin
            hit = 0;
            for (i = 0; i < shadow_len && hit == 0; i++)
               if (shadow_list[i] == w.value) hit = i + 1;
            if (!record) begin
            end else if (shadow_len == 0) begin
               push_result(STAT_EMPTY, '0, '0, 1'b1);
            end else if (hit == 0) begin
               push_result(STAT_NOT_FOUND, '0, '0, 1'b1);
            end else begin
               push_result(STAT_OK, '0, POS_W'(hit), 1'b1);
            end
         end
         default: begin
            if (!record) begin
            end else if (shadow_len == 0) begin
               push_result(STAT_EMPTY, '0, '0, 1'b1);
            end else begin
               for (i = 0; i < shadow_len; i++)
                  push_result(STAT_OK, shadow_list[i], '0, (i + 1 == shadow_len));
            end
         end
      endcase
   endfunction

   function automatic void add_row(input cmd_type c, input logic signed [DATA_W-1:0] v,
                                   input logic [POS_W-1:0] p, input bit typed,
                                   input status_type st, input logic signed [DATA_W-1:0] wv);
      drill_row_type row;
      row.command     = c;
      row.value       = v;
      row.position    = p;
      row.typed       = typed;
      row.want_status = st;
      row.want_value  = wv;
      drill_rows.push_back(row);
   endfunction

   // Grows the list toward full, then shrinks it toward empty, and so on.
   function automatic req_word_type next_random_command(input bit growing);
      req_word_type w;
      int           pick;
      pick = $urandom_range(99);
      if (pick < (growing ? 60 : 15)) w.command = cmd_type'($urandom_range(2));
      else if (pick < 75) w.command = cmd_type'($urandom_range(5, 3));
      else if (pick < 90) w.command = CMD_SEARCH;
      else w.command = CMD_READOUT;
      case ($urandom_range(7))
         0, 1: w.value = $urandom_range(4) - 2;
         2: w.value = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: w.value = $urandom;
      endcase
      if (w.command == CMD_SEARCH && shadow_len > 0 && $urandom_range(99) < 60)
         w.value = shadow_list[$urandom_range(shadow_len - 1)];
      w.position = POS_W'($urandom_range(31));
      if ($urandom_range(99) < 80) begin
         if (w.command == CMD_INS_POS) w.position = POS_W'($urandom_range(shadow_len + 1, 1));
         else if (w.command == CMD_DEL_POS && shadow_len > 0)
            w.position = POS_W'($urandom_range(shadow_len, 1));
      end
      return w;
   endfunction

   task automatic offer(input req_word_type w, input bit typed, input rsp_word_type typed_rsp);
      while (sender_idles && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      list_apply(w, !typed);
      if (typed) rsp_expected.push_back(typed_rsp);
      commands_sent++;
   endtask

   initial begin : stimulus
      rsp_word_type typed_rsp;
      req_word_type w;
      bit           growing;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_word       <= '0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      squeeze        = 1'b0;
      shadow_len     = 0;
      peak_len       = 0;
      growing        = 1'b1;

      add_row(CMD_SEARCH,    0,            0,  1, STAT_EMPTY,     0);
      add_row(CMD_READOUT,   0,            0,  1, STAT_EMPTY,     0);
      add_row(CMD_DEL_FRONT, 0,            0,  1, STAT_EMPTY,     0);
      add_row(CMD_DEL_END,   0,            0,  1, STAT_EMPTY,     0);
      add_row(CMD_DEL_POS,   0,            1,  1, STAT_EMPTY,     0);
      add_row(CMD_INS_POS,   3,            0,  1, STAT_BAD_POS,   0);
      add_row(CMD_INS_POS,   3,            2,  1, STAT_BAD_POS,   0);
      add_row(CMD_INS_END,   32'h7fff_ffff, 0, 1, STAT_OK,        0);
      add_row(CMD_INS_FRONT, 32'h8000_0000, 0, 1, STAT_OK,        0);
      add_row(CMD_INS_POS,   5,            3,  1, STAT_OK,        0);
      add_row(CMD_INS_POS,   -1,           2,  1, STAT_OK,        0);
      add_row(CMD_INS_POS,   5,            1,  1, STAT_OK,        0);
      add_row(CMD_READOUT,   0,            0,  0, STAT_OK,        0);
      add_row(CMD_SEARCH,    5,            0,  0, STAT_OK,        0);
      add_row(CMD_SEARCH,    32'h7fff_ffff, 0, 0, STAT_OK,        0);
      add_row(CMD_DEL_FRONT, 0,            0,  0, STAT_OK,        0);
      add_row(CMD_SEARCH,    5,            0,  0, STAT_OK,        0);
      add_row(CMD_SEARCH,    123,          0,  1, STAT_NOT_FOUND, 0);
      add_row(CMD_DEL_POS,   0,            5,  1, STAT_BAD_POS,   0);
      add_row(CMD_DEL_POS,   0,            31, 1, STAT_BAD_POS,   0);
      add_row(CMD_INS_POS,   7,            31, 1, STAT_BAD_POS,   0);
      add_row(CMD_DEL_POS,   0,            2,  0, STAT_OK,        0);
      add_row(CMD_DEL_END,   0,            0,  0, STAT_OK,        0);
      add_row(CMD_DEL_FRONT, 0,            0,  0, STAT_OK,        0);
      add_row(CMD_DEL_POS,   0,            1,  0, STAT_OK,        0);
      add_row(CMD_READOUT,   0,            0,  1, STAT_EMPTY,     0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (drill_rows[k]) begin
         w.command                = drill_rows[k].command;
         w.value                  = drill_rows[k].value;
         w.position               = drill_rows[k].position;
         typed_rsp.status         = drill_rows[k].want_status;
         typed_rsp.value_out      = drill_rows[k].want_value;
         typed_rsp.found_position = '0;
         typed_rsp.last           = 1'b1;
         offer(w, drill_rows[k].typed, typed_rsp);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 20) squeeze = 1'b1;
         sender_idles   = !(n >= 70 && n < 110);
         receiver_idles = sender_idles;
         if (shadow_len == LIST_DEPTH) growing = 1'b0;
         else if (shadow_len == 0) growing = 1'b1;
         w = next_random_command(growing);
         offer(w, 1'b0, typed_rsp);
      end
      req_valid <= 1'b0;

      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (2 * LIST_DEPTH + 8) @(posedge clock);

      $display("Sent %0d commands, checked %0d result words, longest list %0d entries.",
               commands_sent, words_checked, peak_len);
      $display("Statuses seen: ok %0d, empty %0d, full %0d, bad position %0d, not found %0d.",
               status_tally[STAT_OK], status_tally[STAT_EMPTY], status_tally[STAT_FULL],
               status_tally[STAT_BAD_POS], status_tally[STAT_NOT_FOUND]);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : result_side
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !hold_done) begin
            hold_left = SQUEEZE_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= receiver_idles && ($urandom_range(99) < 27);
         end
      end
   end

   task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_expected.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_word);
            mismatches++;
         end else begin
            want = rsp_expected.pop_front();
            check_field("status", DATA_W'(want.status), DATA_W'(rsp_word.status));
            check_field("value_out", want.value_out, rsp_word.value_out);
            check_field("found_position", DATA_W'(want.found_position),
                        DATA_W'(rsp_word.found_position));
            check_field("last", DATA_W'(want.last), DATA_W'(rsp_word.last));
            status_tally[rsp_word.status]++;
            words_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
